// ===== design/sced_pkg.sv =====
// Shared types and constants of the streaming community edge step block.
// No dependencies; every other file in this folder but sced_ram imports it.
package sced_pkg;

   localparam int NODE_ID_W = 10;
   localparam int COMM_W    = 10;
   localparam int THR_W     = 16;
   localparam int CLASS_W   = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [THR_W-1:0] MIN_THRESHOLD   = 16'd2;
   localparam logic [THR_W-1:0] RESET_THRESHOLD = 16'd2;

   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESHOLD = 2'd0;

   localparam logic [CLASS_W-1:0] CLASS_JOIN   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_LINK   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_IGNORE = 2'd2;

   typedef struct packed {
      logic [NODE_ID_W-1:0] source;
      logic [NODE_ID_W-1:0] target;
   } edge_type;

   typedef struct packed {
      logic     valid;
      edge_type item;
   } queue_head_type;

endpackage

// ===== design/sced_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// A read at the address being written returns the old contents. No dependencies.
module sced_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== design/sced_front.sv =====
// Front end: accepts an edge word and reduces both node ids modulo the table size
// in two halves around the hold register before pushing the edge into the queue. Depends on sced_pkg.
module sced_front import sced_pkg::*; #(
   parameter int NODE_COUNT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NODE_ID_W-1:0] req_source_node,
   input  logic [NODE_ID_W-1:0] req_target_node,
   input  logic                 queue_full,
   input  logic                 clearing,
   output logic                 busy,
   output logic                 push,
   output edge_type             push_edge
);

   logic                 hold_ff, hold_in;
   logic [NODE_ID_W-1:0] src_ff, src_in;
   logic [NODE_ID_W-1:0] tgt_ff, tgt_in;
   logic                 accept;

   // Restoring remainder: the upper half of the steps at acceptance, the lower half after.
   function automatic logic [NODE_ID_W-1:0] reduce_high(input logic [NODE_ID_W-1:0] v);
      logic [31:0] acc;
      logic [31:0] lim;
      acc = 32'(v);
      for (int k = 9; k >= 5; k--) begin
         lim = 32'(NODE_COUNT) << k;
         if (acc >= lim) begin
            acc = acc - lim;
         end
      end
      return acc[NODE_ID_W-1:0];
   endfunction

   function automatic logic [NODE_ID_W-1:0] reduce_low(input logic [NODE_ID_W-1:0] v);
      logic [31:0] acc;
      logic [31:0] lim;
      acc = 32'(v);
      for (int k = 4; k >= 0; k--) begin
         lim = 32'(NODE_COUNT) << k;
         if (acc >= lim) begin
            acc = acc - lim;
         end
      end
      return acc[NODE_ID_W-1:0];
   endfunction

   assign busy   = clearing | hold_ff | queue_full;
   assign accept = start & ~busy;

   always_comb begin
      hold_in = accept;
      src_in  = src_ff;
      tgt_in  = tgt_ff;
      if (accept) begin
         src_in = reduce_high(req_source_node);
         tgt_in = reduce_high(req_target_node);
      end
   end

   assign push             = hold_ff;
   assign push_edge.source = reduce_low(src_ff);
   assign push_edge.target = reduce_low(tgt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      src_ff <= src_in;
      tgt_ff <= tgt_in;
   end

endmodule

// ===== design/sced_queue.sv =====
// Short queue of reduced edges between the front end and the table sequencer.
// Depends on sced_pkg.
module sced_queue import sced_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  edge_type       push_edge,
   input  logic           pop,
   output queue_head_type head,
   output logic           full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   edge_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_edge;
      end
   end

endmodule

// ===== design/sced_back.sv =====
// Back end: owns the node table (degree and community per node) and updates it
// for each edge in an update state and a commit state. Depends on sced_pkg and sced_ram.
module sced_back import sced_pkg::*; #(
   parameter int NODE_COUNT  = 1024,
   parameter int DEGREE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [THR_W-1:0]     threshold,
   input  queue_head_type       head,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   output logic [CLASS_W-1:0]   rsp_edge_class,
   output logic [COMM_W-1:0]    rsp_source_community,
   output logic [COMM_W-1:0]    rsp_target_community
);

   localparam int IDX_W   = $clog2(NODE_COUNT);
   localparam int ENTRY_W = COMM_W + DEGREE_BITS;
   localparam int CMP_W   = (DEGREE_BITS > THR_W) ? DEGREE_BITS : THR_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_COMMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [NODE_ID_W-1:0] cur_src_ff, cur_src_in;
   logic [NODE_ID_W-1:0] cur_tgt_ff, cur_tgt_in;
   logic [NODE_ID_W-1:0] wr_tgt_ff, wr_tgt_in;
   logic [ENTRY_W-1:0]   wr_entry_ff, wr_entry_in;
   logic                 fwd_ff, fwd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0]   rsp_class_ff, rsp_class_in;
   logic [COMM_W-1:0]    rsp_src_ff, rsp_src_in;
   logic [COMM_W-1:0]    rsp_tgt_ff, rsp_tgt_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [ENTRY_W-1:0]   rd_data_a, rd_data_b;
   logic [ENTRY_W-1:0]   ent_s, ent_t;
   logic [DEGREE_BITS-1:0] deg_s, deg_t, sd, td;
   logic [COMM_W-1:0]    com_s, com_t, cs, ct;
   logic [THR_W-1:0]     thr;
   logic [CMP_W-1:0]     sd_c, td_c, thr_c;
   logic [CLASS_W-1:0]   cls;
   logic                 self_loop;

   function automatic logic [DEGREE_BITS-1:0] sat_inc(input logic [DEGREE_BITS-1:0] d);
      return (&d) ? d : d + 1'b1;
   endfunction

   sced_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (IDX_W'(head.item.source)),
      .rd_data_a (rd_data_a),
      .rd_addr_b (IDX_W'(head.item.target)),
      .rd_data_b (rd_data_b)
   );

   // The target entry of the previous edge is still being written when this
   // edge's read is issued, so it is taken from the write register instead.
   always_comb begin
      ent_s = (fwd_ff && cur_src_ff == wr_tgt_ff) ? wr_entry_ff : rd_data_a;
      ent_t = (fwd_ff && cur_tgt_ff == wr_tgt_ff) ? wr_entry_ff : rd_data_b;
      deg_s = ent_s[DEGREE_BITS-1:0];
      deg_t = ent_t[DEGREE_BITS-1:0];
      com_s = (deg_s == '0) ? cur_src_ff : ent_s[ENTRY_W-1 -: COMM_W];
      com_t = (deg_t == '0) ? cur_tgt_ff : ent_t[ENTRY_W-1 -: COMM_W];
      self_loop = (cur_src_ff == cur_tgt_ff);
      sd = self_loop ? sat_inc(sat_inc(deg_s)) : sat_inc(deg_s);
      td = self_loop ? sd : sat_inc(deg_t);
      thr   = (threshold < MIN_THRESHOLD) ? MIN_THRESHOLD : threshold;
      sd_c  = CMP_W'(sd);
      td_c  = CMP_W'(td);
      thr_c = CMP_W'(thr);
      cs = com_s;
      ct = com_t;
      if (sd_c <= thr_c && td_c <= thr_c) begin
         cls = CLASS_JOIN;
         if (sd_c > td_c) begin
            ct = com_s;
         end else begin
            cs = com_t;
         end
      end else if (sd_c >= thr_c && td_c >= thr_c && com_s != com_t) begin
         cls = CLASS_LINK;
      end else begin
         cls = CLASS_IGNORE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_src_in   = cur_src_ff;
      cur_tgt_in   = cur_tgt_ff;
      wr_tgt_in    = wr_tgt_ff;
      wr_entry_in  = wr_entry_ff;
      fwd_in       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_class_in = rsp_class_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_tgt_in   = rsp_tgt_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            wr_en        = 1'b1;
            wr_addr      = IDX_W'(cur_src_ff);
            wr_data      = {cs, sd};
            wr_tgt_in    = cur_tgt_ff;
            wr_entry_in  = {ct, td};
            rsp_valid_in = 1'b1;
            rsp_class_in = cls;
            rsp_src_in   = cs;
            rsp_tgt_in   = ct;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(wr_tgt_ff);
            wr_data = wr_entry_ff;
            if (head.valid) begin
               pop      = 1'b1;
               fwd_in   = 1'b1;
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (pop) begin
         cur_src_in = head.item.source;
         cur_tgt_in = head.item.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_src_ff   <= cur_src_in;
      cur_tgt_ff   <= cur_tgt_in;
      wr_tgt_ff    <= wr_tgt_in;
      wr_entry_ff  <= wr_entry_in;
      rsp_class_ff <= rsp_class_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_tgt_ff   <= rsp_tgt_in;
   end

   assign clearing             = (state_ff == ST_CLEAR);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_edge_class       = rsp_class_ff;
   assign rsp_source_community = rsp_src_ff;
   assign rsp_target_community = rsp_tgt_ff;

endmodule

// ===== design/streaming_community_edge_step.sv =====
// Streaming community edge step: top level with the register port and the wiring
// of front end, queue and back end. Depends on sced_pkg, sced_front, sced_queue, sced_back.
//
// After reset the node table is cleared one entry per cycle; busy stays high meanwhile,
// though register writes are taken as usual. An edge word is taken when start is high
// and busy is low, and its result appears, after the front-end hold register, the
// queue and the back end's update state, on the rsp_ ports with rsp_valid high for a
// single cycle. The receiver cannot stall, so it must take every result as it
// comes. A new edge is not taken while the last one is in the front end's hold
// register, and each edge writes two table entries through the table's single write port.
module streaming_community_edge_step import sced_pkg::*; #(
   parameter int NODE_COUNT  = 1024,
   parameter int DEGREE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [NODE_ID_W-1:0]  req_source_node,
   input  logic [NODE_ID_W-1:0]  req_target_node,
   output logic                  rsp_valid,
   output logic [CLASS_W-1:0]    rsp_edge_class,
   output logic [COMM_W-1:0]     rsp_source_community,
   output logic [COMM_W-1:0]     rsp_target_community,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             push;
   edge_type         push_edge;
   logic             pop;
   logic             queue_full;
   logic             clearing;
   queue_head_type   head;

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && paddr == ADDR_THRESHOLD) begin
         thr_in = pwdata[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= RESET_THRESHOLD;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_THRESHOLD) ? CSR_DATA_W'(thr_ff) : '0;

   sced_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_source_node (req_source_node),
      .req_target_node (req_target_node),
      .queue_full      (queue_full),
      .clearing        (clearing),
      .busy            (busy),
      .push            (push),
      .push_edge       (push_edge)
   );

   sced_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_edge (push_edge),
      .pop       (pop),
      .head      (head),
      .full      (queue_full)
   );

   sced_back #(
      .NODE_COUNT  (NODE_COUNT),
      .DEGREE_BITS (DEGREE_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .threshold            (thr_ff),
      .head                 (head),
      .pop                  (pop),
      .clearing             (clearing),
      .rsp_valid            (rsp_valid),
      .rsp_edge_class       (rsp_edge_class),
      .rsp_source_community (rsp_source_community),
      .rsp_target_community (rsp_target_community)
   );

endmodule
